>>> hw/rtl/srl_pkg.sv
// Shared types and constants for the sorted record list.
// Used by srl_if.sv and sorted_record_list.sv; depends on nothing else.
`default_nettype none

package srl_pkg;

  // Table size and derived widths.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response.
  localparam int NAME_W      = 64;
  localparam int VOL_W       = 32;
  localparam int POS_W       = 7;
  localparam int COUNT_OUT_W = 7;

  // Width that holds both a position and a count for comparison.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

endpackage : srl_pkg

`default_nettype wire

>>> hw/rtl/srl_if.sv
// Request and response channel interfaces of the sorted record list.
// Depends on srl_pkg for field widths and the action type.
`default_nettype none

interface srl_req_if;
  import srl_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [NAME_W-1:0]   key_name;
  logic [VOL_W-1:0]    volume_in;
  logic [POS_W-1:0]    position;

  modport source (output valid, action, key_name, volume_in, position, input ready);
  modport sink   (input valid, action, key_name, volume_in, position, output ready);
endinterface : srl_req_if

interface srl_rsp_if;
  import srl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [NAME_W-1:0]      name_out;
  logic [VOL_W-1:0]       volume_out;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;
  logic                   is_full;

  modport source (output valid, ok, name_out, volume_out, entry_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, ok, name_out, volume_out, entry_count, is_empty, is_full,
                  output ready);
endinterface : srl_rsp_if

`default_nettype wire

>>> hw/rtl/sorted_record_list.sv
// Sorted record list: table memory, sequencer and response register.
// Depends on srl_pkg and the channel interfaces in srl_if.sv.
//
// Usage:
//   The req channel carries one request (insert, remove by name, read by
//   one-based position, or clear). The rsp channel returns exactly one
//   response per request with ok, the read record, and the count, empty and
//   full flags after the operation. One request is handled at a time: req.ready
//   is high only while the sequencer is idle.
//   Steps from acceptance to the response being presented:
//     insert : walks down from the top, reading each entry and moving larger
//              ones up one place until its slot is found; no walk when full
//     remove : the whole list is walked; read, clear : no walk
//   Each entry visited takes a read state and a compare/write state, as the
//   table memory has registered read data. The next request is taken the
//   cycle after the response is loaded into the output register.
//   Reset clears the count and all control state; table contents are left as
//   they are and are never read before being written. When the receiver holds
//   rsp.ready low, the response stays in the output register and the block
//   waits with the next result until the register is free.
`default_nettype none

module sorted_record_list (
  input  logic      clk,
  input  logic      rst,
  srl_req_if.sink   req,
  srl_rsp_if.source rsp
);
  import srl_pkg::*;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_RM_RD   = 6'b001000,
    S_RM_CMP  = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic              found, found_next;
  logic              ok_reg, ok_next;
  action_t           op;
  logic [NAME_W-1:0] key_reg;
  logic [VOL_W-1:0]  vol_reg;

  // Table memory and its ports.
  logic [NAME_W-1:0] mem_name [CAPACITY];
  logic [VOL_W-1:0]  mem_vol  [CAPACITY];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [NAME_W-1:0] wr_name;
  logic [VOL_W-1:0]  wr_vol;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [NAME_W-1:0] rd_name;
  logic [VOL_W-1:0]  rd_vol;

  // Response register.
  logic                   out_valid;
  logic                   out_ok;
  logic [NAME_W-1:0]      out_name;
  logic [VOL_W-1:0]       out_vol;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                   out_empty;
  logic                   out_full;

  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_dec;
  logic [CMP_W-1:0] count_ext;
  logic             pos_ok;
  logic             rec_le;
  logic             resp_free;

  assign idx_dec   = idx - CNT_W'(1);
  assign idx_inc   = idx + CNT_W'(1);
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign pos_ext   = CMP_W'(req.position);
  assign pos_dec   = pos_ext - CMP_W'(1);
  assign count_ext = CMP_W'(count);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
  assign resp_free = !out_valid || rsp.ready;

  // Insert compare: stored record orders at or before the new one.
  assign rec_le = (rd_name != key_reg) ? (rd_name < key_reg) : (rd_vol <= vol_reg);

  assign req.ready = (state == S_IDLE);

  // Sequencer next state and memory port control.
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    found_next = found;
    ok_next    = ok_reg;
    wr_en      = 1'b0;
    wr_addr    = idx[IDX_W-1:0];
    wr_name    = key_reg;
    wr_vol     = vol_reg;
    rd_en      = 1'b0;
    rd_addr    = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.action)
            ACT_INSERT: begin
              if (count == CNT_W'(CAPACITY)) begin
                ok_next    = 1'b0;
                state_next = S_RESP;
              end else begin
                idx_next   = count;
                state_next = S_INS_RD;
              end
            end
            ACT_REMOVE: begin
              idx_next   = '0;
              found_next = 1'b0;
              state_next = S_RM_RD;
            end
            ACT_READ: begin
              // The read data register is valid by the time the response loads.
              ok_next    = pos_ok;
              rd_en      = pos_ok;
              rd_addr    = pos_dec[IDX_W-1:0];
              state_next = S_RESP;
            end
            default: begin
              count_next = '0;
              ok_next    = 1'b1;
              state_next = S_RESP;
            end
          endcase
        end
      end

      // Insert walks down from the top, moving larger entries up one place.
      S_INS_RD: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          count_next = count_inc;
          ok_next    = 1'b1;
          state_next = S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx_dec[IDX_W-1:0];
          state_next = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rec_le) begin
          count_next = count_inc;
          ok_next    = 1'b1;
          state_next = S_RESP;
        end else begin
          wr_name    = rd_name;
          wr_vol     = rd_vol;
          idx_next   = idx_dec;
          state_next = S_INS_RD;
        end
      end

      // Remove walks up from the bottom; after the first match every entry
      // is copied one place down.
      S_RM_RD: begin
        if (idx == count) begin
          ok_next    = found;
          if (found) begin
            count_next = count_dec;
          end
          state_next = S_RESP;
        end else begin
          rd_en      = 1'b1;
          state_next = S_RM_CMP;
        end
      end

      S_RM_CMP: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = idx_dec[IDX_W-1:0];
          wr_name = rd_name;
          wr_vol  = rd_vol;
        end else if (rd_name == key_reg) begin
          found_next = 1'b1;
        end
        idx_next   = idx_inc;
        state_next = S_RM_RD;
      end

      S_RESP: begin
        if (resp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      idx    <= '0;
      found  <= 1'b0;
      ok_reg <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      found  <= found_next;
      ok_reg <= ok_next;
    end
  end

  // Request fields are held for the length of the operation.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op      <= req.action;
      key_reg <= req.key_name;
      vol_reg <= req.volume_in;
    end
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_name[wr_addr] <= wr_name;
      mem_vol[wr_addr]  <= wr_vol;
    end
    if (rd_en) begin
      rd_name <= mem_name[rd_addr];
      rd_vol  <= mem_vol[rd_addr];
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && resp_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload; record fields are zero unless a read succeeded.
  always_ff @(posedge clk) begin
    if (state == S_RESP && resp_free) begin
      out_ok    <= ok_reg;
      out_name  <= (op == ACT_READ && ok_reg) ? rd_name : '0;
      out_vol   <= (op == ACT_READ && ok_reg) ? rd_vol : '0;
      out_count <= COUNT_OUT_W'(count);
      out_empty <= (count == '0);
      out_full  <= (count == CNT_W'(CAPACITY));
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.name_out    = out_name;
  assign rsp.volume_out  = out_vol;
  assign rsp.entry_count = out_count;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;

  // The count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The table is written only by the insert and remove walks.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_INS_RD || state == S_INS_CMP || state == S_RM_CMP))
    else $error("table written outside an insert or remove");

  // The count changes only when an operation finishes.
  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> (state == S_RESP))
    else $error("count changed before the operation finished");

  // The insert compare always looks at an entry below the current slot.
  a_ins_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP) |-> (idx != '0))
    else $error("insert compare with slot zero");

  // A removal walk never runs past the stored entries.
  a_rm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RM_CMP) |-> (idx < count))
    else $error("remove walk past the last entry");

endmodule : sorted_record_list

`default_nettype wire

>>> bench/tb_sorted_record_list.sv
// Testbench for the sorted record list. It sends insert, remove, read and clear
// requests and checks every response against a behavioral copy of the table or a typed row.
// Depends on srl_pkg, the channel interfaces in srl_if.sv and sorted_record_list.sv.

module tb_sorted_record_list;
  timeunit 1ns;
  timeprecision 1ps;
  import srl_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 2 * CAPACITY + 16;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int POOL_SIZE        = 16;
  localparam int REPORT_LIMIT     = 10;

  // Name keys, first character in the top byte, zero padded.
  localparam logic [NAME_W-1:0] NAME_ZERO   = '0;
  localparam logic [NAME_W-1:0] NAME_TOP    = '1;
  localparam logic [NAME_W-1:0] NAME_APPL   = 64'h4150504C_00000000;
  localparam logic [NAME_W-1:0] NAME_APPLE  = 64'h4150504C_45000000;
  localparam logic [NAME_W-1:0] NAME_APPLES = 64'h4150504C_45530000;
  localparam logic [NAME_W-1:0] NAME_BANANA = 64'h42414E41_4E410000;
  localparam logic [VOL_W-1:0]  VOL_TOP     = '1;

  typedef struct packed {
    action_t           action;
    logic [NAME_W-1:0] key_name;
    logic [VOL_W-1:0]  volume_in;
    logic [POS_W-1:0]  position;
  } list_request_t;

  typedef struct packed {
    logic                   ok;
    logic [NAME_W-1:0]      name_out;
    logic [VOL_W-1:0]       volume_out;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic                   is_full;
  } list_result_t;

  // A directed request; when typed is set, res is the expected response.
  typedef struct packed {
    list_request_t req;
    logic          typed;
    list_result_t  res;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // Empty table after reset: reads, remove and clear.
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd1},   1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd0},   1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{'{ACT_REMOVE, NAME_APPLE,  32'd0,   7'd0},   1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{'{ACT_CLEAR,  NAME_ZERO,   32'd0,   7'd0},   1'b1, '{1'b1, NAME_ZERO, 32'd0, 7'd0, 1'b1, 1'b0}},
    // Smallest and largest records, then reads at and past the ends.
    '{'{ACT_INSERT, NAME_ZERO,   32'd0,   7'd0},   1'b1, '{1'b1, NAME_ZERO, 32'd0, 7'd1, 1'b0, 1'b0}},
    '{'{ACT_INSERT, NAME_TOP,    VOL_TOP, 7'd0},   1'b1, '{1'b1, NAME_ZERO, 32'd0, 7'd2, 1'b0, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd1},   1'b1, '{1'b1, NAME_ZERO, 32'd0, 7'd2, 1'b0, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd2},   1'b1, '{1'b1, NAME_TOP, VOL_TOP, 7'd2, 1'b0, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd0},   1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd2, 1'b0, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd3},   1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd2, 1'b0, 1'b0}},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd127}, 1'b1, '{1'b0, NAME_ZERO, 32'd0, 7'd2, 1'b0, 1'b0}},
    // Duplicates, equal names with lower volume, and a prefix name.
    '{'{ACT_INSERT, NAME_APPLE,  32'd5,   7'd0},   1'b0, '0},
    '{'{ACT_INSERT, NAME_APPLE,  32'd5,   7'd0},   1'b0, '0},
    '{'{ACT_INSERT, NAME_APPLE,  32'd2,   7'd0},   1'b0, '0},
    '{'{ACT_INSERT, NAME_APPL,   32'd9,   7'd0},   1'b0, '0},
    '{'{ACT_INSERT, NAME_APPLES, 32'd0,   7'd0},   1'b0, '0},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd2},   1'b0, '0},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd3},   1'b0, '0},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd4},   1'b0, '0},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd5},   1'b0, '0},
    // Remove ignores the volume and takes the first matching name.
    '{'{ACT_REMOVE, NAME_APPLE,  32'd99,  7'd0},   1'b0, '0},
    '{'{ACT_REMOVE, NAME_BANANA, 32'd0,   7'd0},   1'b0, '0},
    '{'{ACT_REMOVE, NAME_ZERO,   32'd0,   7'd0},   1'b0, '0},
    '{'{ACT_READ,   NAME_ZERO,   32'd0,   7'd64},  1'b0, '0},
    '{'{ACT_CLEAR,  NAME_ZERO,   32'd0,   7'd0},   1'b1, '{1'b1, NAME_ZERO, 32'd0, 7'd0, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst;

  srl_req_if req_ch ();
  srl_rsp_if rsp_ch ();

  sorted_record_list i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table, kept in sorted order.
  logic [NAME_W-1:0] book_name [CAPACITY];
  logic [VOL_W-1:0]  book_vol  [CAPACITY];
  int                book_count = 0;

  list_result_t      pending_results [$];
  logic [NAME_W-1:0] name_pool [POOL_SIZE];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                failures = 0;
  int                cycle_count = 0;

  // Applies one request to the shadow table and returns the response it owes.
  function automatic list_result_t apply_request(input list_request_t r);
    list_result_t res;
    int slot;
    int k;
    res = '0;
    case (r.action)
      ACT_INSERT: begin
        if (book_count < CAPACITY) begin
          slot = 0;
          while (slot < book_count &&
                 (book_name[slot] < r.key_name ||
                  (book_name[slot] == r.key_name && book_vol[slot] <= r.volume_in)))
            slot++;
          for (k = book_count; k > slot; k--) begin
            book_name[k] = book_name[k-1];
            book_vol[k]  = book_vol[k-1];
          end
          book_name[slot] = r.key_name;
          book_vol[slot]  = r.volume_in;
          book_count++;
          res.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        slot = 0;
        while (slot < book_count && book_name[slot] != r.key_name)
          slot++;
        if (slot < book_count) begin
          for (k = slot; k + 1 < book_count; k++) begin
            book_name[k] = book_name[k+1];
            book_vol[k]  = book_vol[k+1];
          end
          book_count--;
          res.ok = 1'b1;
        end
      end
      ACT_READ: begin
        if (r.position >= 1 && r.position <= book_count) begin
          res.name_out   = book_name[r.position - 1];
          res.volume_out = book_vol[r.position - 1];
          res.ok         = 1'b1;
        end
      end
      default: begin
        book_count = 0;
        res.ok     = 1'b1;
      end
    endcase
    res.entry_count = COUNT_OUT_W'(book_count);
    res.is_empty    = (book_count == 0);
    res.is_full     = (book_count == CAPACITY);
    return res;
  endfunction

  function automatic string format_result(input list_result_t r);
    return $sformatf("ok=%0b name=%h vol=%h count=%0d empty=%0b full=%0b",
                     r.ok, r.name_out, r.volume_out, r.entry_count, r.is_empty, r.is_full);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // Offers one request after a random gap and waits until the block takes it.
  task automatic drive_request(input list_request_t r, input logic use_typed,
                               input list_result_t typed_res);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= r.action;
    req_ch.key_name  <= r.key_name;
    req_ch.volume_in <= r.volume_in;
    req_ch.position  <= r.position;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_request(r);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic check_response();
    list_result_t got;
    list_result_t want;
    got = '{ok: rsp_ch.ok, name_out: rsp_ch.name_out, volume_out: rsp_ch.volume_out,
            entry_count: rsp_ch.entry_count, is_empty: rsp_ch.is_empty,
            is_full: rsp_ch.is_full};
    if (pending_results.size() == 0) begin
      note_failure({"response with no request pending: ", format_result(got)});
    end else begin
      want = pending_results.pop_front();
      if (got.ok !== want.ok || got.name_out !== want.name_out ||
          got.volume_out !== want.volume_out || got.entry_count !== want.entry_count ||
          got.is_empty !== want.is_empty || got.is_full !== want.is_full)
        note_failure({"expected ", format_result(want), ", got ", format_result(got)});
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Response side: check each accepted response, then stall at random.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        check_response();
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Request side: reset, directed rows, then three phases of random traffic.
  initial begin
    list_request_t r;
    logic [NAME_W-1:0] nm;
    int len;
    int sel;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= ACT_INSERT;
    req_ch.key_name  <= '0;
    req_ch.volume_in <= '0;
    req_ch.position  <= '0;

    // Short names over a three-letter alphabet, so prefixes and ties are common.
    for (int i = 0; i < POOL_SIZE; i++) begin
      nm  = '0;
      len = $urandom_range(8, 1);
      for (int b = 0; b < len; b++)
        nm[NAME_W-1-8*b -: 8] = 8'h41 + 8'($urandom_range(2));
      name_pool[i] = nm;
    end

    send_idle_pct = 17;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      drive_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 17; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      // Fill the table from the pool, then insert into it and read its last entry.
      while (book_count < CAPACITY) begin
        r = '{ACT_INSERT, name_pool[$urandom_range(POOL_SIZE-1)],
              VOL_W'($urandom_range(3)), POS_W'($urandom)};
        drive_request(r, 1'b0, '0);
      end
      r = '{ACT_INSERT, {$urandom, $urandom}, $urandom, POS_W'($urandom)};
      drive_request(r, 1'b0, '0);
      r = '{ACT_READ, {$urandom, $urandom}, $urandom, POS_W'(CAPACITY)};
      drive_request(r, 1'b0, '0);

      // Mixed traffic, mostly on pool names so removes find their targets.
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        sel = $urandom_range(99);
        r.key_name  = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                               : name_pool[$urandom_range(POOL_SIZE-1)];
        r.volume_in = ($urandom_range(1) == 0) ? VOL_W'($urandom_range(3)) : $urandom;
        r.position  = POS_W'($urandom);
        if (sel < 42)
          r.action = ACT_INSERT;
        else if (sel < 67)
          r.action = ACT_REMOVE;
        else if (sel < 97)
          r.action = ACT_READ;
        else
          r.action = ACT_CLEAR;
        if (r.action == ACT_READ && book_count > 0 && $urandom_range(3) != 0)
          r.position = POS_W'($urandom_range(book_count, 1));
        drive_request(r, 1'b0, '0);
      end
    end
    req_ch.valid <= 1'b0;

    // Drain the remaining responses, then give the block time to misbehave.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule : tb_sorted_record_list
